// ----- hw/rtl/circle_elastic_collision_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the disc collision block
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_ELASTIC_COLLISION_MACROS_SVH
`define CIRCLE_ELASTIC_COLLISION_MACROS_SVH

// Same-cycle implication.
`define CEC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define CEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hw/rtl/cec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disc collision package
// Widths, status codes, job records and the saturation helper.
// ----------------------------------------------------------------------------
package cec_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VEL_W      = 32;
	localparam int DIFF_W     = VEL_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int DIST_W     = PROD_W;
	localparam int DOT_W      = PROD_W + 1;
	localparam int MAG_W      = PROD_W;
	localparam int NUM_W      = MAG_W + FRAC_BITS;
	localparam int QUOT_W     = VEL_W + 1;
	localparam int RAD_W      = 10;
	localparam int RSUM_W     = RAD_W + 1;
	localparam int SCALE_W    = 16;
	localparam int CONT_W     = RSUM_W + SCALE_W;
	localparam int CSQ_W      = 2 * CONT_W;
	localparam int CONT_SHIFT = 2 * FRAC_BITS - 16;
	localparam int MUL_W      = DIFF_W + QUOT_W + 1;
	localparam int SUM_W      = MUL_W + 1;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = 4;
	localparam int IN_W       = 280;
	localparam int OUT_W      = 128;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam logic [QUOT_W-1:0]  QUOT_MAX    = QUOT_W'(1) << (VEL_W - 1);

	typedef enum logic [1:0] {
		ST_APART      = 2'd0,
		ST_SEPARATING = 2'd1,
		ST_COINCIDENT = 2'd2,
		ST_IMPULSE    = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vx1;
		logic signed [VEL_W-1:0] vy1;
		logic signed [VEL_W-1:0] vx2;
		logic signed [VEL_W-1:0] vy2;
	} vel_t;

	// One classified pair handed from the front end to the back end.
	typedef struct packed {
		vel_t                     vel;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic [DIST_W-1:0]        dist2;
		logic [MAG_W-1:0]         dot_mag;
		logic                     touching;
		status_t                  status;
	} job_t;

	// Saturate a wide signed sum to a 32-bit velocity.
	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
		logic signed [VEL_W-1:0] r;
		if (v[SUM_W-1:VEL_W-1] != {(SUM_W-VEL_W+1){v[SUM_W-1]}}) begin
			r = v[SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
		end else begin
			r = v[VEL_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/cec_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cec_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  cec_pkg::job_t                       push_data,
	input  logic                                pop,
	output cec_pkg::job_t                       pop_data,
	output logic                                not_empty,
	output logic [cec_pkg::FIFO_CW-1:0]         count
);

	cec_pkg::job_t                 mem_q [cec_pkg::FIFO_DEPTH];
	logic [cec_pkg::FIFO_AW-1:0]   wr_q;
	logic [cec_pkg::FIFO_AW-1:0]   rd_q;
	logic [cec_pkg::FIFO_CW-1:0]   cnt_q;
	logic                          do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// ----- hw/rtl/cec_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Differences, squares, dot product and contact test; classifies each pair.
// ----------------------------------------------------------------------------
module cec_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [cec_pkg::IN_W-1:0]         in_data,
	input  logic [cec_pkg::SCALE_W-1:0]      scale,
	output logic                             push,
	output cec_pkg::job_t                    job,
	output logic [1:0]                       busy
);

	logic signed [cec_pkg::VEL_W-1:0] x1, y1, x2, y2;
	logic [cec_pkg::RAD_W-1:0]        r1, r2;
	cec_pkg::vel_t                    vel_in;

	logic                              v_s1, v_s2, v_s3;
	cec_pkg::vel_t                     vel_s1, vel_s2, vel_s3;
	logic signed [cec_pkg::DIFF_W-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic signed [cec_pkg::DIFF_W-1:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic [cec_pkg::RSUM_W-1:0]        rsum_s1;
	logic signed [cec_pkg::PROD_W-1:0] sqx_s2, sqy_s2, pdx_s2, pdy_s2;
	logic [cec_pkg::CONT_W-1:0]        cont_s2;
	logic [cec_pkg::DIST_W-1:0]        dist2_s3;
	logic signed [cec_pkg::DOT_W-1:0]  dot_s3;
	logic [cec_pkg::CSQ_W-1:0]         csq_s3;

	logic [cec_pkg::DIST_W-1:0]        dist_sh;
	logic                              touch;
	logic [cec_pkg::DOT_W-1:0]         dot_neg;

	assign x1         = in_data[31:0];
	assign y1         = in_data[63:32];
	assign vel_in.vx1 = in_data[95:64];
	assign vel_in.vy1 = in_data[127:96];
	assign x2         = in_data[159:128];
	assign y2         = in_data[191:160];
	assign vel_in.vx2 = in_data[223:192];
	assign vel_in.vy2 = in_data[255:224];
	assign r1         = in_data[265:256];
	assign r2         = in_data[275:266];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		vel_s1  <= vel_in;
		dx_s1   <= {x2[31], x2} - {x1[31], x1};
		dy_s1   <= {y2[31], y2} - {y1[31], y1};
		dvx_s1  <= {vel_in.vx2[31], vel_in.vx2} - {vel_in.vx1[31], vel_in.vx1};
		dvy_s1  <= {vel_in.vy2[31], vel_in.vy2} - {vel_in.vy1[31], vel_in.vy1};
		rsum_s1 <= {1'b0, r1} + {1'b0, r2};

		vel_s2  <= vel_s1;
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		sqx_s2  <= dx_s1 * dx_s1;
		sqy_s2  <= dy_s1 * dy_s1;
		pdx_s2  <= dx_s1 * dvx_s1;
		pdy_s2  <= dy_s1 * dvy_s1;
		cont_s2 <= rsum_s1 * scale;

		vel_s3   <= vel_s2;
		dx_s3    <= dx_s2;
		dy_s3    <= dy_s2;
		dist2_s3 <= {1'b0, sqx_s2[cec_pkg::PROD_W-2:0]} + {1'b0, sqy_s2[cec_pkg::PROD_W-2:0]};
		dot_s3   <= {pdx_s2[cec_pkg::PROD_W-1], pdx_s2} + {pdy_s2[cec_pkg::PROD_W-1], pdy_s2};
		csq_s3   <= cont_s2 * cont_s2;
	end

	// Classification of the pair; coincidence is tested before approach.
	always_comb begin
		dist_sh = dist2_s3 >> cec_pkg::CONT_SHIFT;
		touch   = dist_sh <= cec_pkg::DIST_W'(csq_s3);
		dot_neg = -dot_s3;
		job.vel      = vel_s3;
		job.dx       = dx_s3;
		job.dy       = dy_s3;
		job.dist2    = dist2_s3;
		job.dot_mag  = dot_neg[cec_pkg::MAG_W-1:0];
		job.touching = touch;
		if (!touch) job.status = cec_pkg::ST_APART;
		else if (dist2_s3 == '0) job.status = cec_pkg::ST_COINCIDENT;
		else if (!dot_s3[cec_pkg::DOT_W-1]) job.status = cec_pkg::ST_SEPARATING;
		else job.status = cec_pkg::ST_IMPULSE;
	end

	assign push = v_s3;
	assign busy = 2'({1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3});

endmodule

// ----- hw/rtl/cec_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Pipelined restoring divider, impulse products and saturating update.
// ----------------------------------------------------------------------------
module cec_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  cec_pkg::job_t        job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cec_pkg::vel_t        out_vel,
	output logic                 out_touching,
	output cec_pkg::status_t     out_status
);

	localparam int NSTG = cec_pkg::QUOT_W;

	typedef struct packed {
		cec_pkg::vel_t                     vel;
		logic signed [cec_pkg::DIFF_W-1:0] dx;
		logic signed [cec_pkg::DIFF_W-1:0] dy;
		logic                              touching;
		cec_pkg::status_t                  status;
		logic [cec_pkg::DIST_W-1:0]        den;
		logic [cec_pkg::DIST_W-1:0]        rem;
		logic [cec_pkg::QUOT_W-1:0]        nlo;
		logic [cec_pkg::QUOT_W-1:0]        quo;
		logic                              ovf;
	} div_t;

	typedef struct packed {
		cec_pkg::vel_t                     vel;
		logic                              touching;
		cec_pkg::status_t                  status;
		logic signed [cec_pkg::MUL_W-1:0]  px;
		logic signed [cec_pkg::MUL_W-1:0]  py;
	} mul_t;

	logic                        en;
	logic [cec_pkg::NUM_W-1:0]   num;
	logic [cec_pkg::DIST_W-1:0]  num_hi;
	div_t                        entry;

	// Divider stages: stage k holds the item after k quotient bits.
	logic                        dv_vld_s [NSTG+1];
	div_t                        dv_s     [NSTG+1];
	logic                        mul_vld_s;
	mul_t                        mul_s;
	logic                        out_vld_q;
	cec_pkg::vel_t               out_vel_q;
	logic                        out_touch_q;
	cec_pkg::status_t            out_status_q;

	logic [cec_pkg::QUOT_W-1:0]          qmag;
	logic signed [cec_pkg::QUOT_W:0]     qsgn;
	logic signed [cec_pkg::MUL_W-1:0]    nx, ny, ix, iy;
	cec_pkg::vel_t                       nvel;

	assign en  = !out_vld_q || out_ready;
	assign pop = en && job_valid;

	always_comb begin
		num            = {job.dot_mag, {cec_pkg::FRAC_BITS{1'b0}}};
		num_hi         = cec_pkg::DIST_W'(num[cec_pkg::NUM_W-1:cec_pkg::QUOT_W]);
		entry.vel      = job.vel;
		entry.dx       = job.dx;
		entry.dy       = job.dy;
		entry.touching = job.touching;
		entry.status   = job.status;
		entry.den      = job.dist2;
		entry.rem      = num_hi;
		entry.nlo      = num[cec_pkg::QUOT_W-1:0];
		entry.quo      = '0;
		entry.ovf      = num_hi >= job.dist2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) dv_s[0] <= entry;
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_div
		logic [cec_pkg::DIST_W:0]   trial;
		logic [cec_pkg::DIST_W+1:0] diff;
		logic                       ge;
		div_t                       nxt;

		always_comb begin
			trial   = {dv_s[k].rem, dv_s[k].nlo[cec_pkg::QUOT_W-1]};
			diff    = {1'b0, trial} - {2'b00, dv_s[k].den};
			ge      = !diff[cec_pkg::DIST_W+1];
			nxt     = dv_s[k];
			nxt.rem = ge ? diff[cec_pkg::DIST_W-1:0] : trial[cec_pkg::DIST_W-1:0];
			nxt.nlo = dv_s[k].nlo << 1;
			nxt.quo = {dv_s[k].quo[cec_pkg::QUOT_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) dv_s[k+1] <= nxt;
		end
	end

	// Quotient saturation and impulse products.
	always_comb begin
		if (dv_s[NSTG].ovf || dv_s[NSTG].quo > cec_pkg::QUOT_MAX) qmag = cec_pkg::QUOT_MAX;
		else qmag = dv_s[NSTG].quo;
		qsgn = {1'b0, qmag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			mul_vld_s <= dv_vld_s[NSTG];
			out_vld_q <= mul_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s.vel      <= dv_s[NSTG].vel;
			mul_s.touching <= dv_s[NSTG].touching;
			mul_s.status   <= dv_s[NSTG].status;
			mul_s.px       <= dv_s[NSTG].dx * qsgn;
			mul_s.py       <= dv_s[NSTG].dy * qsgn;
		end
	end

	// The impulse is minus the product, floored by the fraction shift.
	always_comb begin
		nx = -mul_s.px;
		ny = -mul_s.py;
		ix = nx >>> cec_pkg::FRAC_BITS;
		iy = ny >>> cec_pkg::FRAC_BITS;
		nvel = mul_s.vel;
		if (mul_s.status == cec_pkg::ST_IMPULSE) begin
			nvel.vx1 = cec_pkg::sat_vel(cec_pkg::SUM_W'(mul_s.vel.vx1) + cec_pkg::SUM_W'(ix));
			nvel.vy1 = cec_pkg::sat_vel(cec_pkg::SUM_W'(mul_s.vel.vy1) + cec_pkg::SUM_W'(iy));
			nvel.vx2 = cec_pkg::sat_vel(cec_pkg::SUM_W'(mul_s.vel.vx2) - cec_pkg::SUM_W'(ix));
			nvel.vy2 = cec_pkg::sat_vel(cec_pkg::SUM_W'(mul_s.vel.vy2) - cec_pkg::SUM_W'(iy));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vel_q    <= nvel;
			out_touch_q  <= mul_s.touching;
			out_status_q <= mul_s.status;
		end
	end

	assign out_valid    = out_vld_q;
	assign out_vel      = out_vel_q;
	assign out_touching = out_touch_q;
	assign out_status   = out_status_q;

endmodule

// ----- hw/rtl/circle_elastic_collision.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equal-mass elastic disc collision
// Contact test and impulse resolution for one pair of discs per transfer.
// ----------------------------------------------------------------------------
// The block takes one pair of discs per clock cycle while s_tready is high
// and returns one result per pair, in order. A pair passes through the front
// end, the job queue and the back end; its latency is set mainly by the
// 33-stage restoring divider that forms the impulse quotient, one quotient
// bit per stage. Output stalls back up through the back end and then the
// eight-entry queue; the input side keeps taking transfers until the queue
// and the front end together hold eight pairs.
module circle_elastic_collision (
	input  logic          clk,
	input  logic          arst_n,
	// cfg_data: inverse_scale, Q8.8
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data,
	// s_tdata from bit 0: first_x, first_y, first_vx, first_vy, second_x,
	// second_y, second_vx, second_vy (32 bits each), first_radius,
	// second_radius (10 bits each), 4 zero bits
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [279:0]  s_tdata,
	// m_tdata from bit 0: new_first_vx, new_first_vy, new_second_vx,
	// new_second_vy (32 bits each)
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,
	// m_tuser from bit 0: touching (1 bit), status (2 bits)
	output logic [2:0]    m_tuser
);

	logic [cec_pkg::SCALE_W-1:0]  scale_q;
	logic                         in_acc;
	logic                         push;
	cec_pkg::job_t                push_job;
	logic [1:0]                   busy;
	logic                         pop;
	cec_pkg::job_t                pop_job;
	logic                         q_not_empty;
	logic [cec_pkg::FIFO_CW-1:0]  q_count;
	logic [cec_pkg::FIFO_CW:0]    occupancy;
	cec_pkg::vel_t                out_vel;
	logic                         out_touching;
	cec_pkg::status_t             out_status;

	// The scale register must only be changed by the user while the block is
	// idle; the block does not enforce this, and the front end reads it directly.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= cec_pkg::SCALE_RESET;
		end else if (cfg_valid) begin
			scale_q <= cfg_data;
		end
	end

	// Credit check: every pair in the front end already owns a queue slot.
	assign occupancy = {1'b0, q_count} + (cec_pkg::FIFO_CW+1)'(busy);
	assign s_tready  = occupancy < (cec_pkg::FIFO_CW+1)'(cec_pkg::FIFO_DEPTH);
	assign in_acc    = s_tvalid && s_tready;

	cec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_acc),
		.in_data  (s_tdata),
		.scale    (scale_q),
		.push     (push),
		.job      (push_job),
		.busy     (busy)
	);

	cec_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.pop_data  (pop_job),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	cec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_not_empty),
		.job          (pop_job),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_vel      (out_vel),
		.out_touching (out_touching),
		.out_status   (out_status)
	);

	assign m_tdata = {out_vel.vy2, out_vel.vx2, out_vel.vy1, out_vel.vx1};
	assign m_tuser = {out_status, out_touching};

endmodule

// ----- hw/rtl/cec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the result port of the collision block over time.
// ----------------------------------------------------------------------------
`include "circle_elastic_collision_macros.svh"

module cec_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [127:0]  m_tdata,
	input logic [2:0]    m_tuser
);

	// A stalled result keeps its payload.
	`CEC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// Pairs that are apart never report contact.
	`CEC_ASSERT_NOW(a_apart, m_tvalid && m_tuser[2:1] == cec_pkg::ST_APART, !m_tuser[0])
	// Contact always leads to one of the three touching outcomes.
	`CEC_ASSERT_NOW(a_touch, m_tvalid && m_tuser[0], m_tuser[2:1] != cec_pkg::ST_APART)

endmodule

bind circle_elastic_collision cec_checker u_cec_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the equal-mass elastic disc collision block
// Streams disc pairs through the block under random stalls on both sides and
// checks every result, against directed outcomes or a bit-exact predictor of the
// contact test, the approach test, the impulse quotient and the velocity saturation.
// ----------------------------------------------------------------------------
module tb_top;

	// One pair of discs as it travels in s_tdata.
	typedef struct packed {
		logic [9:0]         r2;
		logic [9:0]         r1;
		logic signed [31:0] vy2;
		logic signed [31:0] vx2;
		logic signed [31:0] y2;
		logic signed [31:0] x2;
		logic signed [31:0] vy1;
		logic signed [31:0] vx1;
		logic signed [31:0] y1;
		logic signed [31:0] x1;
	} pair_t;

	// One resolved pair as it leaves the block.
	typedef struct {
		logic               touching;
		cec_pkg::status_t   status;
		logic signed [31:0] n1x;
		logic signed [31:0] n1y;
		logic signed [31:0] n2x;
		logic signed [31:0] n2y;
	} resolution_t;

	// A row of the directed table. Rows marked known carry their outcome
	// inline; their velocities simply pass through.
	typedef struct {
		pair_t            p;
		bit               known;
		bit               touching;
		cec_pkg::status_t status;
	} row_t;

	localparam int N_ROWS      = 11;
	localparam int N_PHASES    = 5;
	localparam int PHASE_ITEMS = 280;
	localparam int DRAIN_WAIT  = 60;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [279:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [2:0]   m_tuser;

	// Shadow of the inverse_scale register, kept in step with every write.
	logic [15:0]  scale_shadow = cec_pkg::SCALE_RESET;
	// Outstanding resolutions, oldest first.
	resolution_t  pending_res[$];
	int           fails = 0;
	int           n_sent = 0;
	int           n_seen = 0;
	int           n_impulse = 0;
	// When set, neither side idles.
	bit           steady = 1'b0;

	row_t         rows[N_ROWS];
	logic [15:0]  scales[N_PHASES];

	circle_elastic_collision u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #10 clk = ~clk;

	// Clamp a wide signed value to the 32-bit velocity range.
	function automatic logic signed [31:0] clamp_vel(input logic signed [127:0] v);
		if (v > 128'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (v < -128'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Works out the result of one pair for the given inverse scale. All
	// intermediate values are held exactly in 128 bits.
	function automatic resolution_t resolve_pair(input pair_t p, input logic [15:0] scale);
		resolution_t        r;
		logic signed [127:0] dx, dy, dvx, dvy, dot, ix, iy, q;
		logic [127:0]        dist2, contact;
		dx = p.x2 - p.x1;
		dy = p.y2 - p.y1;
		dvx = p.vx2 - p.vx1;
		dvy = p.vy2 - p.vy1;
		dist2 = dx * dx + dy * dy;
		contact = p.r1;
		contact = (contact + p.r2) * scale;
		r.touching = (dist2 >> (2 * cec_pkg::FRAC_BITS - 16)) <= contact * contact;
		r.n1x = p.vx1;
		r.n1y = p.vy1;
		r.n2x = p.vx2;
		r.n2y = p.vy2;
		dot = dx * dvx + dy * dvy;
		if (!r.touching) begin
			r.status = cec_pkg::ST_APART;
		end else if (dist2 == 0) begin
			r.status = cec_pkg::ST_COINCIDENT;
		end else if (dot >= 0) begin
			r.status = cec_pkg::ST_SEPARATING;
		end else begin
			// The quotient magnitude saturates at 2^31 before it is negated.
			q = $signed(((-dot) <<< cec_pkg::FRAC_BITS) / $signed(dist2));
			if (q > 128'sh80000000) begin
				q = 128'sh80000000;
			end
			q = -q;
			ix = (dx * q) >>> cec_pkg::FRAC_BITS;
			iy = (dy * q) >>> cec_pkg::FRAC_BITS;
			r.n1x = clamp_vel(p.vx1 + ix);
			r.n1y = clamp_vel(p.vy1 + iy);
			r.n2x = clamp_vel(p.vx2 - ix);
			r.n2y = clamp_vel(p.vy2 - iy);
			r.status = cec_pkg::ST_IMPULSE;
		end
		return r;
	endfunction

	// Random pair. Most pairs sit close together so that the contact and
	// approach tests are reached; the rest are fully random noise.
	function automatic pair_t random_pair();
		pair_t p;
		p.x1 = $urandom;
		p.y1 = $urandom;
		p.x2 = $urandom;
		p.y2 = $urandom;
		p.vx1 = $urandom;
		p.vy1 = $urandom;
		p.vx2 = $urandom;
		p.vy2 = $urandom;
		p.r1 = $urandom_range(0, 1023);
		p.r2 = $urandom_range(0, 1023);
		if ($urandom_range(0, 99) >= 25) begin
			p.x2 = p.x1 + ($signed(32'($urandom)) >>> $urandom_range(0, 31));
			p.y2 = p.y1 + ($signed(32'($urandom)) >>> $urandom_range(0, 31));
			if ($urandom_range(0, 9) == 0) begin
				p.x2 = p.x1;
				p.y2 = p.y1;
			end
			p.vx1 = $signed(32'($urandom)) >>> $urandom_range(0, 20);
			p.vy1 = $signed(32'($urandom)) >>> $urandom_range(0, 20);
			p.vx2 = $signed(32'($urandom)) >>> $urandom_range(0, 20);
			p.vy2 = $signed(32'($urandom)) >>> $urandom_range(0, 20);
		end
		return p;
	endfunction

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 27);
	endfunction

	// Offer one pair and hold it until the block takes the transfer; the
	// expected resolution is queued at the accepting edge.
	task automatic send_pair(input pair_t p, input resolution_t res);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, p};
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_res.push_back(res);
		n_sent++;
	endtask

	// Wait until every result is back and the pipeline has gone quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_scale(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		scale_shadow = v;
	endtask

	// Output side: random back-pressure, and every transfer is compared with
	// the oldest expected resolution.
	always @(posedge clk) begin
		resolution_t e;
		if (m_tvalid && m_tready) begin
			n_seen++;
			if (pending_res.size() == 0) begin
				$error("result transfer with nothing expected");
				fails++;
			end else begin
				e = pending_res.pop_front();
				if (e.status == cec_pkg::ST_IMPULSE) begin
					n_impulse++;
				end
				if (m_tuser[0] !== e.touching) begin
					$error("touching: expected %0d, got %0d", e.touching, m_tuser[0]);
					fails++;
				end
				if (m_tuser[2:1] !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_tuser[2:1]);
					fails++;
				end
				if (m_tdata[31:0] !== e.n1x) begin
					$error("new_first_vx: expected %0d, got %0d", e.n1x,
						$signed(m_tdata[31:0]));
					fails++;
				end
				if (m_tdata[63:32] !== e.n1y) begin
					$error("new_first_vy: expected %0d, got %0d", e.n1y,
						$signed(m_tdata[63:32]));
					fails++;
				end
				if (m_tdata[95:64] !== e.n2x) begin
					$error("new_second_vx: expected %0d, got %0d", e.n2x,
						$signed(m_tdata[95:64]));
					fails++;
				end
				if (m_tdata[127:96] !== e.n2y) begin
					$error("new_second_vy: expected %0d, got %0d", e.n2y,
						$signed(m_tdata[127:96]));
					fails++;
				end
			end
		end
		m_tready <= !idle_now();
	end

	initial begin
		resolution_t res;
		pair_t       p;
		// Directed table: p fields run r2, r1, vy2, vx2, y2, x2, vy1, vx1, y1, x1.
		// All zero: centres coincide, so the discs touch with nothing to resolve.
		rows[0] = '{'{10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
			cec_pkg::ST_COINCIDENT};
		// Opposite ends of the x range with the largest radii: far apart.
		rows[1] = '{'{10'd1023, 10'd1023, 32'sh7FFFFFFF, 32'sh80000000, 0,
			32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh80000000},
			1, 0, cec_pkg::ST_APART};
		// Zero radii on one spot, extreme velocities: still coincident.
		rows[2] = '{'{10'd0, 10'd0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000}, 1, 1, cec_pkg::ST_COINCIDENT};
		// Touching but moving apart.
		rows[3] = '{'{10'd1, 10'd1, 0, 32'sh10000, 0, 32'sh10000, 0, -32'sh10000,
			0, 0}, 1, 1, cec_pkg::ST_SEPARATING};
		// Head-on approach.
		rows[4] = '{'{10'd1, 10'd1, 0, -32'sh10000, 0, 32'sh10000, 0, 32'sh10000,
			0, 0}, 0, 0, cec_pkg::ST_APART};
		// One LSB apart at full closing speed: the quotient saturates.
		rows[5] = '{'{10'd3, 10'd5, 0, 32'sh80000000, 32'sh100, 32'sh101,
			0, 32'sh7FFFFFFF, 32'sh100, 32'sh100}, 0, 0, cec_pkg::ST_APART};
		// Diagonal approach with extreme velocities: sums land exactly on the velocity limits.
		rows[6] = '{'{10'd50, 10'd50, 32'sh80000000, 32'sh80000000, 32'sh30000,
			32'sh30000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0}, 0, 0,
			cec_pkg::ST_APART};
		// Largest radii, exactly at the contact distance, at rest.
		rows[7] = '{'{10'd1023, 10'd1023, 0, 0, 0, 32'sd2046 <<< 16, 0, 0, 0, 0},
			1, 1, cec_pkg::ST_SEPARATING};
		// One LSB beyond the contact distance.
		rows[8] = '{'{10'd1023, 10'd1023, 0, 0, 0, (32'sd2046 <<< 16) + 1, 0, 0,
			0, 0}, 1, 0, cec_pkg::ST_APART};
		// Negative coordinates, oblique approach.
		rows[9] = '{'{10'd4, 10'd2, 32'sh8000, -32'sh18000, -32'sh40000,
			-32'sh20000, -32'sh4000, 32'sh20000, -32'sh50000, -32'sh60000},
			0, 0, cec_pkg::ST_APART};
		// Off-axis glancing contact.
		rows[10] = '{'{10'd7, 10'd9, -32'sh1234, 32'sh777, 32'sh1000,
			32'shF0000, 32'sh5555, -32'sh9999, 32'sh40000, 32'shA0000},
			0, 0, cec_pkg::ST_APART};
		scales = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 65534)),
			cec_pkg::SCALE_RESET};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under the reset scale.
		foreach (rows[i]) begin
			p = rows[i].p;
			if (rows[i].known) begin
				res = '{rows[i].touching, rows[i].status, p.vx1, p.vy1, p.vx2, p.vy2};
			end else begin
				res = resolve_pair(p, scale_shadow);
			end
			send_pair(p, res);
		end
		drain();

		// Random phases, one per scale setting. The second phase runs without
		// any idling on either side.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_scale(scales[ph]);
			steady = (ph == 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				p = random_pair();
				send_pair(p, resolve_pair(p, scale_shadow));
			end
			drain();
			steady = 1'b0;
		end

		$display("covered %0d pairs over %0d scale settings, %0d results checked",
			n_sent, N_PHASES + 1, n_seen);
		$display("impulse resolutions among them: %0d", n_impulse);
		if (fails == 0 && pending_res.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#(20 * 400000);
		$display("timeout with %0d results outstanding", pending_res.size());
		$display("status: fail");
		$finish;
	end

endmodule
